// File: rtl/core/spa_pkg.sv
// shared types and codes for the segment pool allocator
`timescale 1ns / 1ps
package spa_pkg;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NO_SPACE  = 2'd1;
  localparam logic [1:0] ST_BAD_FREE  = 2'd2;
  localparam logic [1:0] ST_TBL_FULL  = 2'd3;

  localparam logic [1:0] MODE_FIRST = 2'd0;
  localparam logic [1:0] MODE_BEST  = 2'd1;
  localparam logic [1:0] MODE_BUMP  = 2'd2;
  localparam logic [1:0] MODE_RSVD  = 2'd3;

  localparam logic CFG_ALIGN = 1'b0;
  localparam logic CFG_MODE  = 1'b1;

  localparam int unsigned REQ_W     = 32;
  localparam int unsigned ALIGN_W   = 16;
  localparam int          ADDR_BITS = 32;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] granted_offset;
    logic [32:0] peak_bytes;
    logic [32:0] in_use_bytes;
    logic [31:0] largest_request;
  } result_t;

endpackage

// File: rtl/core/spa_rounder.sv
// bit-serial remainder unit that rounds a request up to the alignment granule
`timescale 1ns / 1ps
module spa_rounder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] req,
  input  logic [15:0] align,
  output logic        done,
  output logic [32:0] size
);
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic [16:0] rem_r, rem_nxt;
  logic [31:0] req_r, req_nxt;
  logic [15:0] a_r, a_nxt;
  logic        done_r, done_nxt;
  logic [32:0] size_r, size_nxt;
  logic [16:0] trial;

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    req_nxt  = req_r;
    a_nxt    = a_r;
    done_nxt = 1'b0;
    size_nxt = size_r;
    trial    = {rem_r[15:0], req_r[31 - cnt_r[4:0]]};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      req_nxt  = req;
      a_nxt    = (align == 16'd0) ? 16'd1 : align;
    end else if (busy_r) begin
      rem_nxt = (trial >= {1'b0, a_r}) ? trial - {1'b0, a_r} : trial;
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'd31) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
        if (req_r == 32'd0) size_nxt = {17'd0, a_r};
        else if (rem_nxt == 17'd0) size_nxt = {1'b0, req_r};
        else size_nxt = {1'b0, req_r} + {17'd0, a_r} - {16'd0, rem_nxt};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r  <= rem_nxt;
    req_r  <= req_nxt;
    a_r    <= a_nxt;
    size_r <= size_nxt;
  end

  assign done = done_r;
  assign size = size_r;
endmodule

// File: rtl/core/segment_pool_allocator.sv
// segment pool allocator: sequential scan, shift and merge over a segment memory
// allocate rounds the request, then scans the segments and shifts the tail up to split one;
//   bump mode grants at the peak instead; free scans for the offset and merges free neighbours
// throughput: one request at a time, ready only when idle and the result is taken
// the scan and the shift passes walk the segment memory one entry at a time
// reset: synchronous active low, table holds one free segment over the whole pool
`timescale 1ns / 1ps
module segment_pool_allocator #(
  parameter int MAX_SEGMENTS = 64
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [71:0]   in_tdata,  // operation, request_size, free_offset
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [135:0]  out_tdata, // status, granted_offset, peak_bytes, in_use_bytes,
                                   // largest_request
  input  logic          cfg_wr_en,
  input  logic          cfg_index,
  input  logic [15:0]   cfg_data
);
  localparam int ADDR_BITS = spa_pkg::ADDR_BITS;
  localparam int IW = $clog2(MAX_SEGMENTS);
  localparam int CW = IW + 1;
  localparam logic [ADDR_BITS:0] POOL = {1'b1, {ADDR_BITS{1'b0}}};

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_ROUND = 10'b0000000010,
    S_SCAN  = 10'b0000000100,
    S_DECIDE= 10'b0000001000,
    S_SHR   = 10'b0000010000,
    S_FPREV = 10'b0000100000,
    S_FNEXT = 10'b0001000000,
    S_SHL   = 10'b0010000000,
    S_SHL2  = 10'b0100000000,
    S_OUT   = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;

  logic [ADDR_BITS:0] mem_size [MAX_SEGMENTS];
  logic               mem_used [MAX_SEGMENTS];

  logic [15:0]        align_r;
  logic [1:0]         mode_r;
  logic [CW-1:0]      count_r;
  logic [32:0]        peak_r, inuse_r;
  logic [31:0]        largest_r;

  logic               op_r;
  logic [31:0]        req_r, foff_r;
  logic [32:0]        rsize_r;
  logic [CW-1:0]      idx_r;
  logic [ADDR_BITS:0] off_r, pick_off_r, min_d_r, pick_size_r;
  logic [IW-1:0]      pick_r;
  logic               found_r;
  logic [CW-1:0]      end_r;
  logic               phase_r;
  logic [ADDR_BITS:0] acc_r;
  spa_pkg::result_t   res_r;
  logic               ovalid_r;

  logic               rnd_start, rnd_done;
  logic [32:0]        rnd_size;

  spa_rounder u_round (
    .clk   (clk),
    .rst_n (rst_n),
    .start (rnd_start),
    .req   (in_tdata[32:1]),
    .align (align_r),
    .done  (rnd_done),
    .size  (rnd_size)
  );

  // registered read port
  logic [IW-1:0]      rd_addr;
  logic [ADDR_BITS:0] rd_size_r;
  logic               rd_used_r;
  logic               we;
  logic [IW-1:0]      wr_addr;
  logic [ADDR_BITS:0] wr_size;
  logic               wr_used;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_size[wr_addr] <= wr_size;
      mem_used[wr_addr] <= wr_used;
    end
    rd_size_r <= mem_size[rd_addr];
    rd_used_r <= mem_used[rd_addr];
  end

  logic [ADDR_BITS:0] sz_ext;
  assign sz_ext = (ADDR_BITS + 1)'(rsize_r);

  assign in_tready = (state_r == S_IDLE) && !ovalid_r;
  assign rnd_start = (state_r == S_IDLE) && in_tvalid && in_tready
                     && (in_tdata[0] == spa_pkg::OP_ALLOC);

  // walk uses a two-phase read: phase 0 issues the address, phase 1 sees data
  always_comb begin
    rd_addr = idx_r[IW-1:0];
    we      = 1'b0;
    wr_addr = idx_r[IW-1:0];
    wr_size = '0;
    wr_used = 1'b0;
    unique case (state_r)
      S_SHR: begin
        rd_addr = (end_r == '0) ? '0 : IW'(end_r - CW'(1));
        if (phase_r) begin
          we = 1'b1; wr_addr = end_r[IW-1:0];
          if (end_r == CW'(pick_r)) begin
            wr_size = sz_ext; wr_used = 1'b1;
          end else if (end_r == CW'(pick_r) + CW'(1)) begin
            wr_size = pick_size_r - sz_ext; wr_used = 1'b0;
          end else begin
            wr_size = rd_size_r; wr_used = rd_used_r;
          end
        end
      end
      S_SHL, S_SHL2: begin
        rd_addr = IW'(end_r + CW'(1));
        if (phase_r) begin
          we = 1'b1; wr_addr = end_r[IW-1:0]; wr_size = rd_size_r; wr_used = rd_used_r;
        end
      end
      default: ;
    endcase
    if (state_r == S_DECIDE && phase_r) begin
      we = 1'b1; wr_addr = pick_r; wr_size = sz_ext; wr_used = 1'b1;
    end
    if (state_r == S_FPREV && phase_r) begin
      we = 1'b1; wr_addr = pick_r; wr_size = acc_r; wr_used = 1'b0;
    end
    if (state_r == S_FNEXT && phase_r) begin
      we = 1'b1; wr_addr = pick_r; wr_used = 1'b0;
      wr_size = ((CW'(pick_r) + CW'(1) < count_r) && !rd_used_r) ? acc_r + rd_size_r : acc_r;
    end
    if (state_r == S_DECIDE && !phase_r)
      rd_addr = pick_r;
    if (state_r == S_FPREV && !phase_r)
      rd_addr = (pick_r == '0) ? '0 : pick_r - IW'(1);
    if (state_r == S_FNEXT && !phase_r)
      rd_addr = IW'(pick_r + IW'(1));
    // entry 0 covers the pool while in reset
    if (!rst_n) begin
      we = 1'b1; wr_addr = '0; wr_size = POOL; wr_used = 1'b0;
    end
  end

  // main sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      align_r   <= 16'd64;
      mode_r    <= spa_pkg::MODE_FIRST;
      count_r   <= CW'(1);
      peak_r    <= '0;
      inuse_r   <= '0;
      largest_r <= '0;
      ovalid_r  <= 1'b0;
      idx_r     <= '0;
      phase_r   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        if (cfg_index == spa_pkg::CFG_ALIGN) align_r <= cfg_data;
        else mode_r <= cfg_data[1:0];
      end
      if (ovalid_r && out_tready) ovalid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: if (in_tvalid && in_tready) begin
          op_r    <= in_tdata[0];
          req_r   <= in_tdata[32:1];
          foff_r  <= in_tdata[64:33];
          idx_r   <= '0;
          off_r   <= '0;
          found_r <= 1'b0;
          phase_r <= 1'b0;
          res_r.granted_offset <= '0;
          if (in_tdata[0] == spa_pkg::OP_ALLOC) begin
            if (in_tdata[32:1] > largest_r) largest_r <= in_tdata[32:1];
            state_r <= S_ROUND;
          end else begin
            state_r <= S_SCAN;
          end
        end
        S_ROUND: if (rnd_done) begin
          rsize_r <= rnd_size;
          if (mode_r[1]) begin
            if ((ADDR_BITS + 1)'(rnd_size) > POOL - (ADDR_BITS + 1)'(peak_r)) begin
              res_r.status <= spa_pkg::ST_NO_SPACE;
            end else begin
              res_r.status <= spa_pkg::ST_OK;
              res_r.granted_offset <= 32'(peak_r);
              peak_r <= peak_r + rnd_size;
            end
            state_r <= S_OUT;
          end else begin
            state_r <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (!phase_r) begin
            if (idx_r >= count_r) begin
              if (op_r == spa_pkg::OP_FREE) begin
                res_r.status <= spa_pkg::ST_BAD_FREE;
                state_r <= S_OUT;
              end else if (!found_r) begin
                res_r.status <= spa_pkg::ST_NO_SPACE;
                state_r <= S_OUT;
              end else begin
                state_r <= S_DECIDE;
              end
            end else begin
              phase_r <= 1'b1;
            end
          end else begin
            phase_r <= 1'b0;
            idx_r   <= idx_r + CW'(1);
            off_r   <= off_r + rd_size_r;
            if (op_r == spa_pkg::OP_FREE) begin
              if (off_r == (ADDR_BITS + 1)'(foff_r)) begin
                pick_r      <= idx_r[IW-1:0];
                pick_size_r <= rd_size_r;
                acc_r       <= rd_size_r;
                if (rd_used_r) inuse_r <= inuse_r - 33'(rd_size_r);
                res_r.status <= spa_pkg::ST_OK;
                state_r <= S_FPREV;
              end
            end else if (!rd_used_r && rd_size_r >= sz_ext) begin
              if (!found_r || (rd_size_r - sz_ext) < min_d_r) begin
                found_r     <= 1'b1;
                min_d_r     <= rd_size_r - sz_ext;
                pick_r      <= idx_r[IW-1:0];
                pick_off_r  <= off_r;
                pick_size_r <= rd_size_r;
                if (mode_r == spa_pkg::MODE_FIRST) state_r <= S_DECIDE;
              end
            end
          end
        end
        S_DECIDE: begin
          if (pick_size_r == sz_ext) begin
            if (!phase_r) phase_r <= 1'b1;
            else begin
              phase_r <= 1'b0;
              inuse_r <= inuse_r + rsize_r;
              if (33'(pick_off_r + sz_ext) > peak_r) peak_r <= 33'(pick_off_r + sz_ext);
              res_r.granted_offset <= 32'(pick_off_r);
              res_r.status <= spa_pkg::ST_OK;
              state_r <= S_OUT;
            end
          end else if (count_r >= CW'(MAX_SEGMENTS)) begin
            res_r.status <= spa_pkg::ST_TBL_FULL;
            state_r <= S_OUT;
          end else begin
            end_r   <= count_r;
            phase_r <= 1'b0;
            state_r <= S_SHR;
          end
        end
        S_SHR: begin
          if (end_r == CW'(pick_r)) begin
            if (!phase_r) phase_r <= 1'b1;
            else begin
              phase_r <= 1'b0;
              count_r <= count_r + CW'(1);
              inuse_r <= inuse_r + rsize_r;
              if (33'(pick_off_r + sz_ext) > peak_r) peak_r <= 33'(pick_off_r + sz_ext);
              res_r.granted_offset <= 32'(pick_off_r);
              res_r.status <= spa_pkg::ST_OK;
              state_r <= S_OUT;
            end
          end else if (!phase_r) phase_r <= 1'b1;
          else begin
            phase_r <= 1'b0;
            end_r <= end_r - CW'(1);
          end
        end
        S_FPREV: begin
          if (!phase_r) begin
            if (pick_r == '0) state_r <= S_FNEXT;
            else phase_r <= 1'b1;
          end else begin
            phase_r <= 1'b0;
            if (!rd_used_r) begin
              acc_r  <= acc_r + rd_size_r;
              pick_r <= pick_r - IW'(1);
              end_r  <= CW'(pick_r);
              state_r <= S_SHL;
            end else begin
              state_r <= S_FNEXT;
            end
          end
        end
        S_FNEXT: begin
          if (!phase_r) begin
            if (CW'(pick_r) + CW'(1) >= count_r) begin
              phase_r <= 1'b1;
            end else phase_r <= 1'b1;
          end else begin
            phase_r <= 1'b0;
            if ((CW'(pick_r) + CW'(1) < count_r) && !rd_used_r) begin
              acc_r <= acc_r + rd_size_r;
              end_r <= CW'(pick_r) + CW'(1);
              state_r <= S_SHL2;
            end else begin
              state_r <= S_OUT;
            end
          end
        end
        S_SHL, S_SHL2: begin
          if (end_r + CW'(1) >= count_r) begin
            count_r <= count_r - CW'(1);
            phase_r <= 1'b0;
            state_r <= (state_r == S_SHL) ? S_FNEXT : S_OUT;
          end else if (!phase_r) phase_r <= 1'b1;
          else begin
            phase_r <= 1'b0;
            end_r <= end_r + CW'(1);
          end
        end
        S_OUT: begin
          ovalid_r <= 1'b1;
          res_r.peak_bytes      <= peak_r;
          res_r.in_use_bytes    <= inuse_r;
          res_r.largest_request <= largest_r;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = {4'b0, res_r.largest_request, res_r.in_use_bytes,
                       res_r.peak_bytes, res_r.granted_offset, res_r.status};
endmodule

// File: rtl/core/spa_checker.sv
// port-level checks for the segment pool allocator
`timescale 1ns / 1ps
module spa_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [135:0] out_tdata
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result dropped or changed while stalled");
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready)
    else $error("request taken while result pending");
  a_one_at_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second request taken while busy");
  a_grant_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1:0] != 2'd0 |-> out_tdata[33:2] == 32'd0)
    else $error("nonzero offset on failed request");
endmodule

bind segment_pool_allocator spa_checker u_spa_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
